// File: hw/rtl/swpl_pkg.sv
`default_nettype none

package swpl_pkg;

    // default sizes of the exchange
    localparam int COMMAND_BITS_DEF  = 8;
    localparam int RESPONSE_BITS_DEF = 32;

    // register reset values
    localparam logic [7:0]  UNIT_TICKS_RST    = 8'd16;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd400;

    // register indexes (paddr[2])
    localparam logic REG_UNIT_TICKS    = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TX_LOW    = 3'd1,
        PH_TX_HIGH   = 3'd2,
        PH_STOP      = 3'd3,
        PH_WAIT_FALL = 3'd4,
        PH_DELAY     = 3'd5,
        PH_WAIT_RISE = 3'd6
    } phase_t;

    // one result transfer
    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [31:0] response;
        logic [5:0]  bits_received;
    } swpl_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/swpl_seq.sv
`default_nettype none

module swpl_seq #(
    parameter int COMMAND_BITS  = swpl_pkg::COMMAND_BITS_DEF,
    parameter int RESPONSE_BITS = swpl_pkg::RESPONSE_BITS_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   step_en,
    input  wire                   start_req,
    input  wire  [7:0]            command_byte,
    input  wire                   line_in,
    input  wire  [7:0]            unit_ticks,
    input  wire  [15:0]           timeout_ticks,
    output swpl_pkg::swpl_result_t result
);

    localparam int BLW = $clog2(COMMAND_BITS + 1);
    localparam int CW  = $clog2(RESPONSE_BITS + 1);

    swpl_pkg::phase_t         phase_reg, phase_next;
    logic [COMMAND_BITS-1:0]  tx_shift_reg, tx_shift_next;
    logic [BLW-1:0]           bit_left_reg, bit_left_next;
    logic [7:0]               unit_count_reg, unit_count_next;
    logic [1:0]               units_left_reg, units_left_next;
    logic [15:0]              wait_count_reg, wait_count_next;
    logic [RESPONSE_BITS-1:0] rx_data_reg, rx_data_next;
    logic [CW-1:0]            rx_count_reg, rx_count_next;
    logic                     rx_to_reg, rx_to_next;

    // timed segment helpers
    logic [7:0]              uc_inc;
    logic                    unit_wrap;
    logic [1:0]              ul_dec;
    logic                    seg_done;
    // edge wait helpers
    logic [15:0]             wc_inc;
    logic                    wait_expired;
    logic [COMMAND_BITS-1:0] tx_load;
    logic [COMMAND_BITS-1:0] tx_shifted;
    logic [BLW-1:0]          bl_dec;
    logic [CW-1:0]           rxc_inc;
    logic                    done;
    logic [63:0]             rx_ext;
    logic [6:0]              cnt_ext;

    assign uc_inc       = unit_count_reg + 8'd1;
    assign unit_wrap    = (uc_inc >= unit_ticks) || (uc_inc == 8'd0);
    assign ul_dec       = units_left_reg - {1'b0, (units_left_reg != 2'd0)};
    assign seg_done     = unit_wrap && (ul_dec == 2'd0);
    assign wc_inc       = (wait_count_reg != 16'hFFFF) ? wait_count_reg + 16'd1
                                                       : wait_count_reg;
    assign wait_expired = (wc_inc >= timeout_ticks) || (timeout_ticks == 16'd0);
    assign tx_load      = COMMAND_BITS'(command_byte);
    assign tx_shifted   = tx_shift_reg << 1;
    assign bl_dec       = bit_left_reg - BLW'(bit_left_reg != '0);
    assign rxc_inc      = rx_count_reg + CW'(1);

    always_comb begin
        phase_next      = phase_reg;
        tx_shift_next   = tx_shift_reg;
        bit_left_next   = bit_left_reg;
        unit_count_next = unit_count_reg;
        units_left_next = units_left_reg;
        wait_count_next = wait_count_reg;
        rx_data_next    = rx_data_reg;
        rx_count_next   = rx_count_reg;
        rx_to_next      = rx_to_reg;
        done            = 1'b0;

        // tick of a timed segment
        if ((phase_reg == swpl_pkg::PH_TX_LOW) || (phase_reg == swpl_pkg::PH_TX_HIGH) ||
            (phase_reg == swpl_pkg::PH_STOP) || (phase_reg == swpl_pkg::PH_DELAY)) begin
            if (unit_wrap) begin
                unit_count_next = 8'd0;
                units_left_next = ul_dec;
            end else begin
                unit_count_next = uc_inc;
            end
        end

        case (phase_reg)
            swpl_pkg::PH_IDLE: begin
                if (start_req) begin
                    tx_shift_next   = tx_load;
                    bit_left_next   = BLW'(COMMAND_BITS);
                    rx_data_next    = '0;
                    rx_count_next   = '0;
                    rx_to_next      = 1'b0;
                    wait_count_next = 16'd0;
                    phase_next      = swpl_pkg::PH_TX_LOW;
                    units_left_next = tx_load[COMMAND_BITS-1] ? 2'd1 : 2'd3;
                    unit_count_next = 8'd0;
                end
            end
            swpl_pkg::PH_TX_LOW: begin
                if (seg_done) begin
                    phase_next      = swpl_pkg::PH_TX_HIGH;
                    units_left_next = tx_shift_reg[COMMAND_BITS-1] ? 2'd3 : 2'd1;
                    unit_count_next = 8'd0;
                end
            end
            swpl_pkg::PH_TX_HIGH: begin
                if (seg_done) begin
                    bit_left_next   = bl_dec;
                    tx_shift_next   = tx_shifted;
                    unit_count_next = 8'd0;
                    if (bl_dec == '0) begin
                        phase_next      = swpl_pkg::PH_STOP;
                        units_left_next = 2'd1;
                    end else begin
                        phase_next      = swpl_pkg::PH_TX_LOW;
                        units_left_next = tx_shifted[COMMAND_BITS-1] ? 2'd1 : 2'd3;
                    end
                end
            end
            swpl_pkg::PH_STOP: begin
                if (seg_done) begin
                    phase_next      = swpl_pkg::PH_WAIT_FALL;
                    wait_count_next = 16'd0;
                end
            end
            swpl_pkg::PH_WAIT_FALL: begin
                if (!line_in) begin
                    phase_next      = swpl_pkg::PH_DELAY;
                    units_left_next = 2'd2;
                    unit_count_next = 8'd0;
                end else begin
                    wait_count_next = wc_inc;
                    if (wait_expired) begin
                        rx_to_next = 1'b1;
                        done       = 1'b1;
                    end
                end
            end
            swpl_pkg::PH_DELAY: begin
                if (seg_done) begin
                    if (rx_count_reg < CW'(RESPONSE_BITS)) begin
                        for (int i = 0; i < RESPONSE_BITS; i++) begin
                            if (i == RESPONSE_BITS - 1 - int'(rx_count_reg)) begin
                                rx_data_next[i] = rx_data_reg[i] | line_in;
                            end
                        end
                        rx_count_next = rxc_inc;
                    end
                    if (rx_count_next >= CW'(RESPONSE_BITS)) begin
                        done = 1'b1;
                    end else begin
                        phase_next      = swpl_pkg::PH_WAIT_RISE;
                        wait_count_next = 16'd0;
                    end
                end
            end
            swpl_pkg::PH_WAIT_RISE: begin
                if (line_in) begin
                    phase_next      = swpl_pkg::PH_WAIT_FALL;
                    wait_count_next = 16'd0;
                end else begin
                    wait_count_next = wc_inc;
                    if (wait_expired) begin
                        rx_to_next = 1'b1;
                        done       = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = swpl_pkg::PH_IDLE;
            end
        endcase

        if (done) begin
            phase_next = swpl_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= swpl_pkg::PH_IDLE;
            tx_shift_reg   <= '0;
            bit_left_reg   <= '0;
            unit_count_reg <= 8'd0;
            units_left_reg <= 2'd0;
            wait_count_reg <= 16'd0;
            rx_data_reg    <= '0;
            rx_count_reg   <= '0;
            rx_to_reg      <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            tx_shift_reg   <= tx_shift_next;
            bit_left_reg   <= bit_left_next;
            unit_count_reg <= unit_count_next;
            units_left_reg <= units_left_next;
            wait_count_reg <= wait_count_next;
            rx_data_reg    <= rx_data_next;
            rx_count_reg   <= rx_count_next;
            rx_to_reg      <= rx_to_next;
        end
    end

    assign rx_ext  = 64'(rx_data_next);
    assign cnt_ext = 7'(rx_count_next);

    always_comb begin
        result.drive_low     = (phase_reg == swpl_pkg::PH_TX_LOW) ||
                               (phase_reg == swpl_pkg::PH_STOP);
        result.busy_res      = (phase_next != swpl_pkg::PH_IDLE);
        result.done_res      = done;
        result.timed_out     = done & rx_to_next;
        result.response      = rx_ext[31:0];
        result.bits_received = cnt_ext[5:0];
    end

endmodule

`default_nettype wire

// File: hw/rtl/single_wire_pulse_link_master.sv
// Master side of a single-wire pulse-width link.
// Input channel (s_*): one transfer per clock tick of the link sequencer,
//   carrying start_req, command_byte and the sampled line level line_in.
// Result channel (m_*): exactly one transfer per input transfer, giving the
//   line drive for that tick, busy/done/timed_out status, the response bits
//   received so far and their count.
// Latency: a result is presented in the cycle after its input is taken.
// Throughput: one item per cycle while not stalled; the sequencer step is a
//   single pass of logic between the state registers and the result register.
// Stall: the result register holds while m_ready is low; s_ready drops only
//   while a result is held and not being taken, so no tick is lost.
// Reset (aresetn low, synchronous): sequencer idle, response and count zero,
//   no result pending, unit_ticks = 16, timeout_ticks = 400.
// Config: APB write at byte 0 (unit_ticks) or 4 (timeout_ticks); write only
//   while no result is outstanding.
`default_nettype none

module single_wire_pulse_link_master #(
    parameter int COMMAND_BITS  = swpl_pkg::COMMAND_BITS_DEF,
    parameter int RESPONSE_BITS = swpl_pkg::RESPONSE_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // APB-style config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_start_req,
    input  wire  [7:0]  s_command_byte,
    input  wire         s_line_in,
    // result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_drive_low,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic        m_timed_out,
    output logic [31:0] m_response,
    output logic [5:0]  m_bits_received
);

    logic [7:0]             unit_ticks_reg;
    logic [15:0]            timeout_ticks_reg;
    logic                   cfg_wr;
    logic                   s_accept;
    logic                   m_valid_reg, m_valid_next;
    swpl_pkg::swpl_result_t step_res;
    swpl_pkg::swpl_result_t res_reg;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg    <= swpl_pkg::UNIT_TICKS_RST;
            timeout_ticks_reg <= swpl_pkg::TIMEOUT_TICKS_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                swpl_pkg::REG_UNIT_TICKS:    unit_ticks_reg    <= pwdata[7:0];
                swpl_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            swpl_pkg::REG_UNIT_TICKS:    prdata = {24'd0, unit_ticks_reg};
            swpl_pkg::REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // take a tick whenever the result slot is free or being emptied
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    swpl_seq #(
        .COMMAND_BITS  (COMMAND_BITS),
        .RESPONSE_BITS (RESPONSE_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (s_accept),
        .start_req     (s_start_req),
        .command_byte  (s_command_byte),
        .line_in       (s_line_in),
        .unit_ticks    (unit_ticks_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (step_res)
    );

    // result register
    assign m_valid_next = s_accept || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_low     = res_reg.drive_low;
    assign m_busy_res      = res_reg.busy_res;
    assign m_done_res      = res_reg.done_res;
    assign m_timed_out     = res_reg.timed_out;
    assign m_response      = res_reg.response;
    assign m_bits_received = res_reg.bits_received;

endmodule

`default_nettype wire

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swpl_pkg::*;

    localparam int CMD_BITS     = COMMAND_BITS_DEF;
    localparam int RESP_BITS    = RESPONSE_BITS_DEF;
    localparam int RANDOM_TICKS = 300;   // random part stops once this many ticks are queued
    localparam int STALL_LIMIT  = 4000;  // cycles without any transfer before giving up

    // One sequencer tick as offered on the input channel
    typedef struct packed {
        logic       start;
        logic [7:0] cmd;
        logic       line;
    } link_tick_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic        s_start_req    = 1'b0;
    logic [7:0]  s_command_byte = '0;
    logic        s_line_in      = 1'b0;

    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_drive_low;
    logic        m_busy_res;
    logic        m_done_res;
    logic        m_timed_out;
    logic [31:0] m_response;
    logic [5:0]  m_bits_received;

    single_wire_pulse_link_master u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_req     (s_start_req),
        .s_command_byte  (s_command_byte),
        .s_line_in       (s_line_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_low     (m_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_timed_out     (m_timed_out),
        .m_response      (m_response),
        .m_bits_received (m_bits_received)
    );

    // ------------------------------------------------------------------
    // Link sequencer predictor: own copy of registers and state
    // ------------------------------------------------------------------
    logic [7:0]          unit_ticks_cfg    = UNIT_TICKS_RST;
    logic [15:0]         timeout_ticks_cfg = TIMEOUT_TICKS_RST;

    phase_t              link_phase    = PH_IDLE;
    logic [CMD_BITS-1:0] cmd_shift     = '0;
    int                  cmd_bits_left = 0;
    logic [7:0]          seg_ticks     = '0;   // ticks into the current unit
    int                  seg_units     = 0;    // units left in the timed segment
    logic [15:0]         edge_wait     = '0;   // saturating edge-wait counter
    logic [31:0]         rx_word       = '0;
    int                  rx_count      = 0;
    logic                rx_timeout    = 1'b0;

    // Pending ticks, expected per-tick outputs, bookkeeping
    link_tick_t   tick_q[$];
    swpl_result_t link_outputs_q[$];
    link_tick_t   cur_tick;
    int           n_pushed   = 0;
    int           n_accepted = 0;
    int           n_errors   = 0;
    int           n_results  = 0;
    int           n_ends     = 0;
    int           n_timeouts = 0;
    int           n_full     = 0;

    function automatic void enter_segment(phase_t ph, int units);
        link_phase = ph;
        seg_units  = units;
        seg_ticks  = '0;
    endfunction

    // one tick of a timed segment; 1 once all its units have elapsed
    function automatic bit segment_elapsed();
        seg_ticks = seg_ticks + 8'd1;
        if (seg_ticks >= unit_ticks_cfg || seg_ticks == 8'd0) begin
            seg_ticks = '0;
            if (seg_units > 0)
                seg_units--;
            return seg_units == 0;
        end
        return 1'b0;
    endfunction

    // one tick of an edge wait; 1 once it has expired
    function automatic bit edge_wait_expired();
        if (edge_wait != 16'hFFFF)
            edge_wait = edge_wait + 16'd1;
        return (edge_wait >= timeout_ticks_cfg) || (timeout_ticks_cfg == 16'd0);
    endfunction

    function automatic int low_units();
        return cmd_shift[CMD_BITS-1] ? 1 : 3;
    endfunction

    // Advance the sequencer by one tick and return the outputs it shows
    function automatic swpl_result_t next_link_outputs(link_tick_t tk);
        swpl_result_t r;
        logic         done;
        r    = '0;
        done = 1'b0;
        // drive follows the phase held at the start of the tick
        r.drive_low = (link_phase == PH_TX_LOW) || (link_phase == PH_STOP);
        case (link_phase)
            PH_IDLE: begin
                if (tk.start) begin
                    cmd_shift     = tk.cmd;
                    cmd_bits_left = CMD_BITS;
                    rx_word       = '0;
                    rx_count      = 0;
                    rx_timeout    = 1'b0;
                    edge_wait     = '0;
                    enter_segment(PH_TX_LOW, low_units());
                end
            end
            PH_TX_LOW: begin
                if (segment_elapsed())
                    enter_segment(PH_TX_HIGH, 4 - low_units());
            end
            PH_TX_HIGH: begin
                if (segment_elapsed()) begin
                    if (cmd_bits_left > 0)
                        cmd_bits_left--;
                    cmd_shift = cmd_shift << 1;
                    if (cmd_bits_left == 0)
                        enter_segment(PH_STOP, 1);
                    else
                        enter_segment(PH_TX_LOW, low_units());
                end
            end
            PH_STOP: begin
                if (segment_elapsed()) begin
                    link_phase = PH_WAIT_FALL;
                    edge_wait  = '0;
                end
            end
            PH_WAIT_FALL: begin
                if (!tk.line) begin
                    enter_segment(PH_DELAY, 2);
                end else if (edge_wait_expired()) begin
                    rx_timeout = 1'b1;
                    done       = 1'b1;
                end
            end
            PH_DELAY: begin
                if (segment_elapsed()) begin
                    if (rx_count < RESP_BITS) begin
                        rx_word[RESP_BITS-1-rx_count] = tk.line;
                        rx_count++;
                    end
                    if (rx_count >= RESP_BITS) begin
                        done = 1'b1;
                    end else begin
                        link_phase = PH_WAIT_RISE;
                        edge_wait  = '0;
                    end
                end
            end
            PH_WAIT_RISE: begin
                if (tk.line) begin
                    link_phase = PH_WAIT_FALL;
                    edge_wait  = '0;
                end else if (edge_wait_expired()) begin
                    rx_timeout = 1'b1;
                    done       = 1'b1;
                end
            end
            default: link_phase = PH_IDLE;
        endcase
        if (done)
            link_phase = PH_IDLE;
        r.busy_res      = (link_phase != PH_IDLE);
        r.done_res      = done;
        r.timed_out     = done & rx_timeout;
        r.response      = rx_word;
        r.bits_received = rx_count[5:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued ticks, idles ~20% outside the calm window
    // ------------------------------------------------------------------
    int drv_cycle = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            drv_cycle <= 0;
        end else begin
            drv_cycle <= drv_cycle + 1;
            if (s_valid && s_ready) begin
                link_outputs_q.push_back(next_link_outputs(cur_tick));
                n_accepted++;
            end
            // a held tick stays put until its transfer completes
            if (!s_valid || s_ready) begin
                if (tick_q.size() != 0 &&
                    ((drv_cycle >= 1000 && drv_cycle < 1600) ||
                     $urandom_range(99, 0) >= 20)) begin
                    cur_tick        = tick_q.pop_front();
                    s_valid        <= 1'b1;
                    s_start_req    <= cur_tick.start;
                    s_command_byte <= cur_tick.cmd;
                    s_line_in      <= cur_tick.line;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, a calm window, and two long
    // hold-offs so the result register fills and s_ready drops
    // ------------------------------------------------------------------
    int rcv_cycle = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rcv_cycle <= 0;
        end else begin
            rcv_cycle <= rcv_cycle + 1;
            if ((rcv_cycle >= 300 && rcv_cycle < 600) ||
                (rcv_cycle >= 1800 && rcv_cycle < 2000))
                m_ready <= 1'b0;
            else if (rcv_cycle >= 1000 && rcv_cycle < 1600)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99, 0) >= 20);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result transfer against the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin
        swpl_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (link_outputs_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $time);
                n_errors++;
            end else begin
                want = link_outputs_q.pop_front();
                compare_field("drive_low", 32'(want.drive_low), 32'(m_drive_low));
                compare_field("busy_res", 32'(want.busy_res), 32'(m_busy_res));
                compare_field("done_res", 32'(want.done_res), 32'(m_done_res));
                compare_field("timed_out", 32'(want.timed_out), 32'(m_timed_out));
                compare_field("response", want.response, m_response);
                compare_field("bits_received", 32'(want.bits_received),
                              32'(m_bits_received));
                if (want.done_res) begin
                    n_ends++;
                    if (want.timed_out)
                        n_timeouts++;
                    if (want.bits_received == 6'd32)
                        n_full++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer on either channel
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input logic start, input logic [7:0] cmd, input logic line);
        link_tick_t tk;
        tk.start = start;
        tk.cmd   = cmd;
        tk.line  = line;
        tick_q.push_back(tk);
        n_pushed++;
    endtask

    // registers of zero behave as one
    function automatic int unit_eff();
        return (unit_ticks_cfg == 8'd0) ? 1 : int'(unit_ticks_cfg);
    endfunction

    function automatic int timeout_eff();
        return (timeout_ticks_cfg == 16'd0) ? 1 : int'(timeout_ticks_cfg);
    endfunction

    task automatic wait_accepted();
        while (n_accepted != n_pushed)
            @(posedge aclk);
    endtask

    // keep feeding a released line until the sequencer is back to idle;
    // a pending edge wait then runs into its timeout
    task automatic settle_link();
        wait_accepted();
        while (link_phase != PH_IDLE) begin
            repeat (64)
                push_tick(1'b0, 8'($urandom_range(255, 0)), 1'b1);
            wait_accepted();
        end
    endtask

    // nothing in flight, result register drained, sequencer idle
    task automatic quiesce();
        settle_link();
        while (link_outputs_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // APB write, then read back
    task automatic program_reg(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        logic [31:0] got;
        want = (idx == REG_UNIT_TICKS) ? {24'd0, value[7:0]} : {16'd0, value[15:0]};
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // write lands on this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_UNIT_TICKS)
            unit_ticks_cfg = value[7:0];
        else
            timeout_ticks_cfg = value[15:0];
        @(posedge aclk);
        psel    <= 1'b1;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $display("%0t: register readback, expected 0x%0h, actual 0x%0h", $time, want, got);
            n_errors++;
        end
    endtask

    // A plausible slave: command sent (line noise ignored meanwhile), then
    // nbits response cells of 1 or 3 units low with jittered edges.
    // A stuck exchange ends with the line held low past the timeout.
    task automatic send_exchange(input logic [7:0] cmd, input int nbits, input bit stuck);
        int   u;
        int   t;
        int   lo;
        int   hi;
        int   gap;
        logic b;
        u = unit_eff();
        t = timeout_eff();
        push_tick(1'b1, cmd, 1'b1);
        // command cells and stop pulse; start requests here must be ignored
        repeat (33 * u)
            push_tick(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                      1'($urandom_range(1, 0)));
        gap = $urandom_range(2, 0);
        if (gap > t - 1)
            gap = t - 1;
        repeat (gap)
            push_tick(1'b0, 8'($urandom_range(255, 0)), 1'b1);
        repeat (nbits) begin
            b = 1'($urandom_range(1, 0));
            if (b)
                lo = u + $urandom_range(u / 2, 0);
            else
                lo = 3 * u - $urandom_range(u / 2, 0);
            hi = 4 * u - lo + $urandom_range(u / 2, 0);
            if (hi > t)
                hi = t;
            repeat (lo)
                push_tick(1'b0, 8'($urandom_range(255, 0)), 1'b0);
            repeat (hi)
                push_tick(1'b0, 8'($urandom_range(255, 0)), 1'b1);
        end
        if (stuck)
            repeat (2 * u + t + 3)
                push_tick(1'b0, 8'($urandom_range(255, 0)), 1'b0);
        settle_link();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int u;
        int t;
        int roll;
        int rand_base;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, at reset register values: idle line noise, a start with
        // an all-zero command, two more starts while busy (ignored), then the
        // wait for the first response edge runs into the default timeout.
        push_tick(1'b0, 8'hFF, 1'b0);
        push_tick(1'b0, 8'h00, 1'b1);
        push_tick(1'b1, 8'h00, 1'b1);
        push_tick(1'b1, 8'hFF, 1'b0);
        push_tick(1'b1, 8'hFF, 1'b1);
        push_tick(1'b0, 8'h5A, 1'b0);
        settle_link();

        // zero registers behave as one tick
        quiesce();
        program_reg(REG_UNIT_TICKS, 32'd0);
        program_reg(REG_TIMEOUT_TICKS, 32'd0);
        send_exchange(8'hA5, 32, 1'b0);
        send_exchange(8'h3C, 3, 1'b1);

        // shortest unit, longest timeout: one full response
        quiesce();
        program_reg(REG_UNIT_TICKS, 32'd1);
        program_reg(REG_TIMEOUT_TICKS, 32'd65535);
        send_exchange(8'($urandom_range(255, 0)), 32, 1'b0);

        // Random settings, mostly short units; one exchange or unstructured ticks per setting
        rand_base = n_pushed;
        while (n_pushed - rand_base < RANDOM_TICKS) begin
            quiesce();
            if ($urandom_range(9, 0) < 7)
                u = $urandom_range(3, 1);
            else
                u = $urandom_range(6, 4);
            roll = $urandom_range(9, 0);
            if (roll < 5)
                t = 4 * u + $urandom_range(16, 0);
            else if (roll < 8)
                t = $urandom_range(u + 2, 1);
            else
                t = $urandom_range(300, 1);
            program_reg(REG_UNIT_TICKS, u);
            program_reg(REG_TIMEOUT_TICKS, t);
            roll = $urandom_range(19, 0);
            if (roll < 10) begin
                send_exchange(8'($urandom_range(255, 0)), 32, 1'b0);
            end else if (roll < 15) begin
                send_exchange(8'($urandom_range(255, 0)), $urandom_range(31, 0), 1'b0);
            end else if (roll < 18) begin
                send_exchange(8'($urandom_range(255, 0)), $urandom_range(31, 0), 1'b1);
            end else begin
                // unstructured ticks, stray starts included
                repeat (40)
                    push_tick($urandom_range(3, 0) == 0, 8'($urandom_range(255, 0)),
                              1'($urandom_range(1, 0)));
                settle_link();
            end
        end

        // drain until every tick is taken and every expected result has arrived
        wait_accepted();
        while (link_outputs_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("checked %0d tick results; %0d exchanges ended, %0d by timeout",
                 n_results, n_ends, n_timeouts);
        $display("%0d full 32-bit responses; reset timing, zero registers and short units",
                 n_full);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/swpl_pkg.sv
hw/rtl/swpl_seq.sv
hw/rtl/single_wire_pulse_link_master.sv
tb/tb.sv
